FILE: sv/fodn_pkg.sv
package fodn_pkg;

    localparam int unsigned VAL_W  = 32;
    localparam int unsigned SLOT_W = 3;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned ACC_W  = 2 * VAL_W + 2;

    localparam int unsigned DEF_NUM_SLOTS  = 7;
    localparam int unsigned DEF_DATA_WIDTH = 32;
    localparam int unsigned DEF_FRAC_BITS  = 24;

    localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SUB   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NEG   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MUL   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DIV   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RECIP = 3'd5;

    // Multiplier operand sources.
    typedef enum logic [2:0] {
        SRC_A,
        SRC_B,
        SRC_L,
        SRC_R,
        SRC_RC,
        SRC_TMP
    } src_t;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_load;
        logic mul_go;
        src_t x_sel;
        src_t y_sel;
        logic acc_go;
        logic acc_clear;
        logic rnd_go;
        logic neg_go;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] held_kind;
        logic              first;
        logic              div_done;
    } status_t;

    // Clamp a wide signed value to the signed range of sat_w bits.
    function automatic logic signed [VAL_W-1:0] sat_val(
        input logic signed [ACC_W-1:0] v,
        input int unsigned             sat_w
    );
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = (ACC_W'(1) <<< (sat_w - 1)) - ACC_W'(1);
        lo = -hi - ACC_W'(1);
        if (v > hi) begin
            return hi[VAL_W-1:0];
        end
        else if (v < lo) begin
            return lo[VAL_W-1:0];
        end
        return v[VAL_W-1:0];
    endfunction

endpackage

FILE: sv/first_order_dual_number_alu.sv
// Add, subtract and negate write their result directly; multiply runs a multiply-accumulate
// program, as do later slots of reciprocal and divide; slot 0 of reciprocal and divide first
// runs the bit-serial divider, whose run grows with FRAC_BITS once 2*FRAC_BITS exceeds 31.
// One request at a time; the next is accepted in the cycle after its result enters the
// output register, and a finished result waits while the output register is still full.
// Reset (rst_n, asynchronous, active low) clears held state and empties the output register.
module first_order_dual_number_alu #(
    parameter int unsigned NUM_SLOTS  = fodn_pkg::DEF_NUM_SLOTS,
    parameter int unsigned DATA_WIDTH = fodn_pkg::DEF_DATA_WIDTH,
    parameter int unsigned FRAC_BITS  = fodn_pkg::DEF_FRAC_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,    // slot[2:0], a_value[34:3], b_value[66:35], zero fill
    input  logic [2:0]  s_tuser,    // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // out_slot[2:0], result_value[34:3], zero fill
    output logic        m_tuser,    // zero_divide
    output logic        m_tlast     // last
);
    import fodn_pkg::*;

    cmd_t    cmd;
    status_t status;

    logic [SLOT_W-1:0]       out_slot;
    logic signed [VAL_W-1:0] out_value;

    fodn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    fodn_datapath #(
        .NUM_SLOTS  (NUM_SLOTS),
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_kind   (s_tuser),
        .in_slot   (s_tdata[2:0]),
        .in_a      (s_tdata[34:3]),
        .in_b      (s_tdata[66:35]),
        .out_slot  (out_slot),
        .out_value (out_value),
        .out_last  (m_tlast),
        .out_zdiv  (m_tuser)
    );

    assign m_tdata = {5'b00000, out_value, out_slot};

endmodule

FILE: sv/fodn_div.sv
module fodn_div #(
    parameter int unsigned DATA_WIDTH = fodn_pkg::DEF_DATA_WIDTH,
    parameter int unsigned FRAC_BITS  = fodn_pkg::DEF_FRAC_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [fodn_pkg::VAL_W-1:0]    divisor,
    output logic                                 done,
    output logic signed [fodn_pkg::VAL_W-1:0]    quotient
);
    import fodn_pkg::*;

    localparam int unsigned SAT_W = (DATA_WIDTH < VAL_W) ? DATA_WIDTH : VAL_W;
    localparam int unsigned NUM_W = ((2 * FRAC_BITS > VAL_W - 1) ? 2 * FRAC_BITS : VAL_W - 1) + 1;
    localparam int unsigned CNT_W = $clog2(NUM_W + 1);
    localparam logic [NUM_W-1:0] MAX_Q = NUM_W'((64'd1 << (SAT_W - 1)) - 64'd1);
    localparam logic [NUM_W-1:0] LAST_CNT = NUM_W'(NUM_W - 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [VAL_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] nq_reg, nq_next;
    logic [VAL_W-1:0] ud_reg, ud_next;
    logic             neg_reg, neg_next;

    logic [VAL_W-1:0] ud_in;
    logic [VAL_W:0]   rem_sh;
    logic [VAL_W:0]   rem_sub;
    logic             ge;

    assign ud_in   = divisor[VAL_W-1] ? VAL_W'(-divisor) : VAL_W'(divisor);
    assign rem_sh  = {rem_reg, nq_reg[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, ud_reg};
    assign ge      = (rem_sh >= {1'b0, ud_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        nq_next   = nq_reg;
        ud_next   = ud_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            ud_next   = ud_in;
            neg_next  = divisor[VAL_W-1];
            // Numerator 2^(2F) plus half the divisor rounds the quotient.
            nq_next   = (NUM_W'(1) << (2 * FRAC_BITS)) + NUM_W'(ud_in >> 1);
        end
        else if (busy_reg) begin
            rem_next = ge ? rem_sub[VAL_W-1:0] : rem_sh[VAL_W-1:0];
            nq_next  = {nq_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (NUM_W'(cnt_reg) == LAST_CNT) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        nq_reg  <= nq_next;
        ud_reg  <= ud_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        if (!neg_reg) begin
            quotient = (nq_reg > MAX_Q) ? VAL_W'(MAX_Q) : VAL_W'(nq_reg);
        end
        else begin
            quotient = (nq_reg > MAX_Q + NUM_W'(1)) ? -VAL_W'(MAX_Q) - VAL_W'(1)
                                                    : -VAL_W'(nq_reg);
        end
    end

    assign done = done_reg;

endmodule

FILE: sv/fodn_datapath.sv
module fodn_datapath #(
    parameter int unsigned NUM_SLOTS  = fodn_pkg::DEF_NUM_SLOTS,
    parameter int unsigned DATA_WIDTH = fodn_pkg::DEF_DATA_WIDTH,
    parameter int unsigned FRAC_BITS  = fodn_pkg::DEF_FRAC_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fodn_pkg::cmd_t                        cmd,
    output fodn_pkg::status_t                     status,
    input  logic [fodn_pkg::KIND_W-1:0]           in_kind,
    input  logic [fodn_pkg::SLOT_W-1:0]           in_slot,
    input  logic signed [fodn_pkg::VAL_W-1:0]     in_a,
    input  logic signed [fodn_pkg::VAL_W-1:0]     in_b,
    output logic [fodn_pkg::SLOT_W-1:0]           out_slot,
    output logic signed [fodn_pkg::VAL_W-1:0]     out_value,
    output logic                                  out_last,
    output logic                                  out_zdiv
);
    import fodn_pkg::*;

    localparam int unsigned SAT_W = (DATA_WIDTH < VAL_W) ? DATA_WIDTH : VAL_W;
    localparam logic [4:0] LAST_SLOT = 5'(NUM_SLOTS - 1);

    // Operation state held from slot 0.
    logic [KIND_W-1:0]       kind_reg;
    logic signed [VAL_W-1:0] left_reg;
    logic signed [VAL_W-1:0] right_reg;
    logic signed [VAL_W-1:0] recip_reg;
    logic                    fault_reg;

    // Current request and working registers.
    logic [SLOT_W-1:0]         slot_reg;
    logic                      first_reg;
    logic signed [VAL_W-1:0]   a_reg;
    logic signed [VAL_W-1:0]   b_reg;
    logic signed [2*VAL_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [VAL_W-1:0]   tmp_reg;

    logic [SLOT_W-1:0]       oslot_reg;
    logic signed [VAL_W-1:0] oval_reg;
    logic                    olast_reg;
    logic                    ozdiv_reg;

    logic signed [VAL_W-1:0]   x_val;
    logic signed [VAL_W-1:0]   y_val;
    logic signed [2*VAL_W-1:0] prod_next;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   rsum;
    logic signed [VAL_W-1:0]   rnd_val;
    logic signed [VAL_W-1:0]   neg_val;
    logic signed [VAL_W-1:0]   res_val;
    logic signed [VAL_W-1:0]   divisor;
    logic signed [VAL_W-1:0]   div_q;
    logic                      div_done;

    function automatic logic signed [VAL_W-1:0] pick(input src_t sel,
                                                      input logic signed [VAL_W-1:0] a,
                                                      input logic signed [VAL_W-1:0] b,
                                                      input logic signed [VAL_W-1:0] l,
                                                      input logic signed [VAL_W-1:0] r,
                                                      input logic signed [VAL_W-1:0] rc,
                                                      input logic signed [VAL_W-1:0] t);
        case (sel)
            SRC_A:   return a;
            SRC_B:   return b;
            SRC_L:   return l;
            SRC_R:   return r;
            SRC_RC:  return rc;
            SRC_TMP: return t;
            default: return '0;
        endcase
    endfunction

    assign divisor = (kind_reg == KIND_DIV) ? right_reg : left_reg;

    fodn_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign x_val = pick(cmd.x_sel, a_reg, b_reg, left_reg, right_reg, recip_reg, tmp_reg);
    assign y_val = pick(cmd.y_sel, a_reg, b_reg, left_reg, right_reg, recip_reg, tmp_reg);
    assign prod_next = x_val * y_val;
    assign acc_next  = (cmd.acc_clear ? ACC_W'(0) : acc_reg) + ACC_W'(prod_reg);

    // Round to nearest with ties toward plus infinity, then clamp.
    assign rsum    = acc_reg + (ACC_W'(1) <<< (FRAC_BITS - 1));
    assign rnd_val = sat_val(rsum >>> FRAC_BITS, SAT_W);
    assign neg_val = sat_val(-ACC_W'(tmp_reg), SAT_W);

    always_comb
    begin
        case (kind_reg)
            KIND_ADD:   res_val = sat_val(ACC_W'(a_reg) + ACC_W'(b_reg), SAT_W);
            KIND_SUB:   res_val = sat_val(ACC_W'(a_reg) - ACC_W'(b_reg), SAT_W);
            KIND_NEG:   res_val = sat_val(-ACC_W'(a_reg), SAT_W);
            KIND_MUL:   res_val = tmp_reg;
            KIND_DIV:   res_val = tmp_reg;
            KIND_RECIP: res_val = first_reg ? recip_reg : tmp_reg;
            default:    res_val = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            kind_reg  <= '0;
            left_reg  <= '0;
            right_reg <= '0;
            recip_reg <= '0;
            fault_reg <= 1'b0;
        end
        else begin
            if (cmd.accept && (in_slot == '0)) begin
                kind_reg  <= in_kind;
                left_reg  <= in_a;
                right_reg <= in_b;
                recip_reg <= '0;
                fault_reg <= 1'b0;
            end
            if (cmd.div_start) begin
                fault_reg <= (divisor == '0);
            end
            if (cmd.div_load) begin
                recip_reg <= div_q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept) begin
            slot_reg  <= in_slot;
            first_reg <= (in_slot == '0);
            a_reg     <= in_a;
            b_reg     <= in_b;
        end
        if (cmd.mul_go) begin
            prod_reg <= prod_next;
        end
        if (cmd.acc_go) begin
            acc_reg <= acc_next;
        end
        if (cmd.rnd_go) begin
            tmp_reg <= rnd_val;
        end
        else if (cmd.neg_go) begin
            tmp_reg <= neg_val;
        end
        if (cmd.load_out) begin
            oslot_reg <= slot_reg;
            oval_reg  <= res_val;
            olast_reg <= ({2'b00, slot_reg} == LAST_SLOT);
            ozdiv_reg <= ((kind_reg == KIND_DIV) || (kind_reg == KIND_RECIP)) && fault_reg;
        end
    end

    assign status.held_kind = kind_reg;
    assign status.first     = first_reg;
    assign status.div_done  = div_done;

    assign out_slot  = oslot_reg;
    assign out_value = oval_reg;
    assign out_last  = olast_reg;
    assign out_zdiv  = ozdiv_reg;

endmodule

FILE: sv/fodn_ctrl.sv
module fodn_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output fodn_pkg::cmd_t    cmd,
    input  fodn_pkg::status_t status
);
    import fodn_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DECODE   = 4'd1;
    localparam logic [3:0] ST_DIV_GO   = 4'd2;
    localparam logic [3:0] ST_DIV_WAIT = 4'd3;
    localparam logic [3:0] ST_MUL      = 4'd4;
    localparam logic [3:0] ST_ACC      = 4'd5;
    localparam logic [3:0] ST_RND      = 4'd6;
    localparam logic [3:0] ST_NEG      = 4'd7;
    localparam logic [3:0] ST_WRITE    = 4'd8;

    typedef struct packed {
        src_t x_sel;
        src_t y_sel;
        logic clear;
        logic rnd;
        logic neg;
        logic last;
    } mul_op_t;

    logic [3:0] state_reg, state_next;
    logic [1:0] step_reg, step_next;
    logic       valid_reg, valid_next;
    mul_op_t    op;

    // Multiply-accumulate program for each operation and slot position.
    function automatic mul_op_t program_op(input logic [KIND_W-1:0] kind,
                                           input logic first,
                                           input logic [1:0] step);
        mul_op_t o;
        o = '{x_sel: SRC_A, y_sel: SRC_B, clear: 1'b1, rnd: 1'b1, neg: 1'b0, last: 1'b1};
        case (kind)
            KIND_MUL:
            begin
                if (!first) begin
                    case (step)
                        2'd0:    o = '{SRC_L, SRC_B, 1'b1, 1'b0, 1'b0, 1'b0};
                        default: o = '{SRC_R, SRC_A, 1'b0, 1'b1, 1'b0, 1'b1};
                    endcase
                end
            end
            KIND_DIV:
            begin
                if (first) begin
                    o = '{SRC_A, SRC_RC, 1'b1, 1'b1, 1'b0, 1'b1};
                end
                else begin
                    // Quotient rule: derivative of the reciprocal, then L*q + r*a.
                    case (step)
                        2'd0:    o = '{SRC_B, SRC_RC, 1'b1, 1'b1, 1'b0, 1'b0};
                        2'd1:    o = '{SRC_TMP, SRC_RC, 1'b1, 1'b1, 1'b1, 1'b0};
                        2'd2:    o = '{SRC_L, SRC_TMP, 1'b1, 1'b0, 1'b0, 1'b0};
                        default: o = '{SRC_RC, SRC_A, 1'b0, 1'b1, 1'b0, 1'b1};
                    endcase
                end
            end
            KIND_RECIP:
            begin
                case (step)
                    2'd0:    o = '{SRC_A, SRC_RC, 1'b1, 1'b1, 1'b0, 1'b0};
                    default: o = '{SRC_TMP, SRC_RC, 1'b1, 1'b1, 1'b1, 1'b1};
                endcase
            end
            default:
            begin
                o.last = 1'b1;
            end
        endcase
        return o;
    endfunction

    assign op = program_op(status.held_kind, status.first, step_reg);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        valid_next = valid_reg;
        cmd        = '0;
        cmd.x_sel  = op.x_sel;
        cmd.y_sel  = op.y_sel;
        cmd.acc_clear = op.clear;
        s_tready   = 1'b0;

        if (valid_reg && m_tready) begin
            valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                step_next = '0;
                if (status.held_kind == KIND_MUL) begin
                    state_next = ST_MUL;
                end
                else if ((status.held_kind == KIND_DIV) || (status.held_kind == KIND_RECIP)) begin
                    state_next = status.first ? ST_DIV_GO : ST_MUL;
                end
                else begin
                    state_next = ST_WRITE;
                end
            end
            ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done) begin
                    cmd.div_load = 1'b1;
                    state_next   = (status.held_kind == KIND_RECIP) ? ST_WRITE : ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_go = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc_go = 1'b1;
                if (op.rnd) begin
                    state_next = ST_RND;
                end
                else if (op.last) begin
                    state_next = ST_WRITE;
                end
                else begin
                    step_next  = step_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_RND:
            begin
                cmd.rnd_go = 1'b1;
                if (op.neg) begin
                    state_next = ST_NEG;
                end
                else if (op.last) begin
                    state_next = ST_WRITE;
                end
                else begin
                    step_next  = step_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_NEG:
            begin
                cmd.neg_go = 1'b1;
                if (op.last) begin
                    state_next = ST_WRITE;
                end
                else begin
                    step_next  = step_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_WRITE:
            begin
                // The output register frees up in the same cycle it is taken.
                if (!valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;

endmodule
